FILE: rtl/core/u8dec_pkg.sv
`default_nettype none
package u8dec_pkg;

  localparam int unsigned CP_W   = 21;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned LEN_W  = 3;
  // worst case: rejected four-byte sequence plus end marker
  localparam int unsigned MAX_RES = 5;
  localparam int unsigned RES_IDX_W = 3;

  typedef logic [CP_W-1:0]      cp_t;
  typedef logic [KIND_W-1:0]    kind_t;
  typedef logic [LEN_W-1:0]     len_t;
  typedef logic [RES_IDX_W-1:0] res_idx_t;

  localparam kind_t KIND_VALID = 2'd0;
  localparam kind_t KIND_REPL  = 2'd1;
  localparam kind_t KIND_END   = 2'd2;

  localparam cp_t REPL_RESET   = 21'h00FFFD;
  localparam cp_t SURR_LO      = 21'h00D800;
  localparam cp_t SURR_HI      = 21'h00DFFF;
  localparam cp_t CP_MAX       = 21'h10FFFF;
  localparam cp_t MIN_LEN2     = 21'h000080;
  localparam cp_t MIN_LEN3     = 21'h000800;
  localparam cp_t MIN_LEN4     = 21'h010000;

endpackage
`default_nettype wire

FILE: rtl/core/u8dec_if.sv
`default_nettype none
interface u8dec_in_if import u8dec_pkg::*;;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_string;

  modport source (output valid, output data_byte, output end_of_string, input ready);
  modport sink   (input valid, input data_byte, input end_of_string, output ready);
endinterface

interface u8dec_out_if import u8dec_pkg::*;;
  logic  valid;
  logic  ready;
  cp_t   code_point;
  kind_t result_kind;
  logic  last_of_run;

  modport source (output valid, output code_point, output result_kind, output last_of_run,
                  input ready);
  modport sink   (input valid, input code_point, input result_kind, input last_of_run,
                  output ready);
endinterface
`default_nettype wire

FILE: rtl/core/utf8_validating_decoder_top.sv
`default_nettype none
// streaming utf-8 decoder with validation. one byte enters per request on in_ch, and
// zero to five results leave on out_ch, the last of each run flagged by last_of_run.
// a byte is decoded in the cycle it is accepted and its whole run of results is
// loaded into a result buffer, which drains one result per cycle while the sink is
// ready. a byte that gives one result (plain ascii, a completed sequence) or none (a
// lead or continuation byte) is accepted every cycle while the sink keeps up, since
// the next byte is taken in the same cycle the last result of the previous run
// leaves. a byte that gives n results holds the input until all n leave the buffer's
// single output port. invalid input gives the replacement value written on cfg
// (reset 0xfffd); the user must write cfg only while the block is idle, unenforced.
module utf8_validating_decoder_top import u8dec_pkg::*; (
  input  wire       clk,
  input  wire       rst_n,
  input  wire       cfg_wr_en,
  input  wire cp_t  cfg_wr_data,
  u8dec_in_if.sink    in_ch,
  u8dec_out_if.source out_ch
);

  // decoder state
  cp_t  pv_r, pv_nxt;           // bits of the pending sequence
  len_t exp_r, exp_nxt;         // expected length, zero when nothing pending
  len_t br_r, br_nxt;           // bytes of the pending sequence so far
  logic drop_r, drop_nxt;       // dropping bytes after a zero terminator
  cp_t  repl_r;

  // result buffer
  logic     busy_r, busy_nxt;
  res_idx_t cnt_r, cnt_nxt;
  res_idx_t idx_r, idx_nxt;
  kind_t    kinds_r [MAX_RES];
  kind_t    kinds_nxt [MAX_RES];
  cp_t      vcp_r, vcp_nxt;     // the one valid code point a run can carry

  logic in_fire, out_fire, run_done;

  assign run_done    = (idx_r == cnt_r - res_idx_t'(1));
  assign in_ch.ready = !busy_r || (out_ch.ready && run_done);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = busy_r && out_ch.ready;

  // output side reads straight from the buffer registers
  assign out_ch.valid       = busy_r;
  assign out_ch.result_kind = kinds_r[idx_r];
  assign out_ch.last_of_run = run_done;
  always_comb begin
    case (kinds_r[idx_r])
      KIND_VALID: out_ch.code_point = vcp_r;
      KIND_REPL:  out_ch.code_point = repl_r;
      default:    out_ch.code_point = '0;
    endcase
  end

  // decode of one byte into its run of results
  logic [7:0] b;
  logic       eos;
  logic       pend, cont, consumed, closed, bad;
  cp_t        acc;
  len_t       br_inc;
  res_idx_t   n;

  always_comb begin
    b        = in_ch.data_byte;
    eos      = in_ch.end_of_string;
    pv_nxt   = pv_r;
    exp_nxt  = exp_r;
    br_nxt   = br_r;
    drop_nxt = drop_r;
    vcp_nxt  = vcp_r;
    for (int k = 0; k < MAX_RES; k++) begin
      kinds_nxt[k] = KIND_END;
    end
    n        = '0;
    consumed = 1'b0;
    closed   = 1'b0;
    bad      = 1'b0;
    pend     = (exp_r != '0);
    cont     = ((b & 8'hC0) == 8'h80);
    acc      = {pv_r[CP_W-7:0], b[5:0]};
    br_inc   = br_r + len_t'(1);

    if (drop_r) begin
      if (eos) begin
        drop_nxt = 1'b0;
      end
    end else begin
      if (pend && cont) begin
        consumed = 1'b1;
        pv_nxt   = acc;
        br_nxt   = br_inc;
        if (br_inc >= exp_r) begin
          // complete sequence: reject overlong, surrogate and out of range forms
          bad = ((exp_r == len_t'(2)) && (acc < MIN_LEN2)) ||
                ((exp_r == len_t'(3)) && (acc < MIN_LEN3)) ||
                ((exp_r == len_t'(4)) && (acc < MIN_LEN4)) ||
                ((acc >= SURR_LO) && (acc <= SURR_HI)) ||
                (acc > CP_MAX);
          if (bad) begin
            for (int i = 0; i < 4; i++) begin
              if (len_t'(i) < exp_r) begin
                kinds_nxt[n] = KIND_REPL;
                n = n + res_idx_t'(1);
              end
            end
          end else begin
            kinds_nxt[n] = KIND_VALID;
            vcp_nxt      = acc;
            n = n + res_idx_t'(1);
          end
          pv_nxt  = '0;
          exp_nxt = '0;
          br_nxt  = '0;
        end
      end else if (pend) begin
        // broken sequence, byte is taken again as a lead below
        kinds_nxt[n] = KIND_REPL;
        n = n + res_idx_t'(1);
        pv_nxt  = '0;
        exp_nxt = '0;
        br_nxt  = '0;
      end

      if (!consumed) begin
        if (b == 8'h00) begin
          kinds_nxt[n] = KIND_END;
          n = n + res_idx_t'(1);
          closed = 1'b1;
          if (!eos) begin
            drop_nxt = 1'b1;
          end
        end else if (b < 8'h80) begin
          kinds_nxt[n] = KIND_VALID;
          vcp_nxt      = cp_t'(b);
          n = n + res_idx_t'(1);
        end else if (b[7:5] == 3'b110) begin
          exp_nxt = len_t'(2);
          br_nxt  = len_t'(1);
          pv_nxt  = cp_t'(b[4:0]);
        end else if (b[7:4] == 4'b1110) begin
          exp_nxt = len_t'(3);
          br_nxt  = len_t'(1);
          pv_nxt  = cp_t'(b[3:0]);
        end else if (b[7:3] == 5'b11110) begin
          exp_nxt = len_t'(4);
          br_nxt  = len_t'(1);
          pv_nxt  = cp_t'(b[2:0]);
        end else begin
          kinds_nxt[n] = KIND_REPL;
          n = n + res_idx_t'(1);
        end
      end

      if (eos && !closed) begin
        // end flag: flush an incomplete sequence, then the end marker
        if (exp_nxt != '0) begin
          kinds_nxt[n] = KIND_REPL;
          n = n + res_idx_t'(1);
          pv_nxt  = '0;
          exp_nxt = '0;
          br_nxt  = '0;
        end
        kinds_nxt[n] = KIND_END;
        n = n + res_idx_t'(1);
      end
    end
  end

  // buffer control
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    idx_nxt  = idx_r;
    if (in_fire) begin
      busy_nxt = (n != '0);
      cnt_nxt  = n;
      idx_nxt  = '0;
    end else if (out_fire) begin
      if (run_done) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + res_idx_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r   <= '0;
      exp_r  <= '0;
      br_r   <= '0;
      drop_r <= 1'b0;
      repl_r <= REPL_RESET;
      busy_r <= 1'b0;
      cnt_r  <= '0;
      idx_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        repl_r <= cfg_wr_data;
      end
      if (in_fire) begin
        pv_r   <= pv_nxt;
        exp_r  <= exp_nxt;
        br_r   <= br_nxt;
        drop_r <= drop_nxt;
      end
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      idx_r  <= idx_nxt;
    end
  end

  // payload of the buffer, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      kinds_r <= kinds_nxt;
      vcp_r   <= vcp_nxt;
    end
  end

endmodule
`default_nettype wire
